### src/imucpu_pkg.sv
// Shared types, constants and helper functions for the IMU channel packet unpacker.
package imucpu_pkg;

  // Channel slots per packet; the last slot is consumed but never reported
  localparam int unsigned ChannelSlots = 16;
  localparam int unsigned PosWidth     = 6;
  localparam int unsigned ChWidth      = 4;
  localparam int unsigned CurWidth     = 5;
  localparam int unsigned FifoDepth    = 4;
  localparam int unsigned FifoPtrWidth = $clog2(FifoDepth);

  localparam logic [PosWidth-1:0] PosMax   = '1;
  localparam logic [CurWidth-1:0] ChDone   = CurWidth'(ChannelSlots);
  localparam logic [ChWidth-1:0]  ChLast   = ChWidth'(ChannelSlots - 2);
  localparam logic [ChWidth-1:0]  ChUnused = ChWidth'(ChannelSlots - 1);

  // Register indexes of the configuration port
  localparam int unsigned CfgIdxWidth = 3;
  localparam logic [CfgIdxWidth-1:0] CfgChannelMask = 3'd0;
  localparam logic [CfgIdxWidth-1:0] CfgGainAngle   = 3'd1;
  localparam logic [CfgIdxWidth-1:0] CfgGainRate    = 3'd2;
  localparam logic [CfgIdxWidth-1:0] CfgGainMagnet  = 3'd3;
  localparam logic [CfgIdxWidth-1:0] CfgGainGyro    = 3'd4;
  localparam logic [CfgIdxWidth-1:0] CfgGainAccel   = 3'd5;

  // Register reset values
  localparam logic [15:0] RstChannelMask = 16'hE000;
  localparam logic [15:0] RstGainAngle   = 16'd720;
  localparam logic [15:0] RstGainRate    = 16'd900;
  localparam logic [15:0] RstGainMagnet  = 16'd4000;
  localparam logic [15:0] RstGainGyro    = 16'd1188;
  localparam logic [15:0] RstGainAccel   = 16'd10084;

  // Work request from the front to the back: emit channels first_ch up to end_ch - 1
  typedef struct packed {
    logic               status;     // mask mismatch
    logic               has_value;  // first channel carries raw, the rest are zero
    logic [ChWidth-1:0] first_ch;
    logic [ChWidth-1:0] end_ch;
    logic [15:0]        raw;
  } cmd_t;

  typedef struct packed {
    logic  push;
    cmd_t  cmd;
  } front_req_t;

  typedef enum logic {
    BK_IDLE,
    BK_EMIT
  } back_state_e;

  // Lowest channel at or after from whose mask bit is set, or ChDone
  function automatic logic [CurWidth-1:0] first_set(input logic [15:0]         mask,
                                                    input logic [CurWidth-1:0] from);
    logic [CurWidth-1:0] res;
    res = ChDone;
    for (int c = ChannelSlots - 1; c >= 0; c--) begin
      if (CurWidth'(c) >= from && mask[ChannelSlots-1-c]) begin
        res = CurWidth'(c);
      end
    end
    return res;
  endfunction

  // Clip a channel pointer to the range that produces results
  function automatic logic [ChWidth-1:0] clip_end(input logic [CurWidth-1:0] ch);
    logic [ChWidth-1:0] res;
    res = (ch > CurWidth'(ChUnused)) ? ChUnused : ch[ChWidth-1:0];
    return res;
  endfunction

  // Gain group of a channel
  function automatic logic [15:0] gain_sel(input logic [ChWidth-1:0] ch,
                                           input logic [15:0] g_angle,
                                           input logic [15:0] g_rate,
                                           input logic [15:0] g_magnet,
                                           input logic [15:0] g_gyro,
                                           input logic [15:0] g_accel);
    logic [15:0] res;
    case (ch) inside
      [4'd0:4'd2]:  res = g_angle;
      [4'd3:4'd5]:  res = g_rate;
      [4'd6:4'd8]:  res = g_magnet;
      [4'd9:4'd11]: res = g_gyro;
      default:      res = g_accel;
    endcase
    return res;
  endfunction

endpackage

### src/imucpu_if.sv
// Handshake interfaces for packet bytes and unpacked channel results.
interface imucpu_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_start;

  modport source (output valid, output packet_byte, output packet_start, input ready);
  modport sink   (input valid, input packet_byte, input packet_start, output ready);
endinterface

interface imucpu_res_if;
  logic               valid;
  logic               ready;
  logic [3:0]         channel;
  logic signed [15:0] raw_value;
  logic signed [31:0] scaled_value;
  logic               status;
  logic               last;

  modport source (output valid, output channel, output raw_value, output scaled_value,
                  output status, output last, input ready);
  modport sink   (input valid, input channel, input raw_value, input scaled_value,
                  input status, input last, output ready);
endinterface

### src/imucpu_front.sv
// Front end: tracks packet position, checks the mask and issues emit requests.
module imucpu_front #(
  parameter int unsigned HEADER_BYTES = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic [7:0]              packet_byte_i,
  input  logic                    packet_start_i,
  input  logic [15:0]             channel_mask_i,
  output imucpu_pkg::front_req_t  req_o
);
  import imucpu_pkg::*;

  localparam logic [PosWidth-1:0] HdrPos    = PosWidth'(HEADER_BYTES);
  localparam logic [PosWidth-1:0] MaskLoPos = PosWidth'(HEADER_BYTES + 1);

  logic [PosWidth-1:0] pos_q, pos_d, pos_e;
  logic [7:0]          mask_hi_q, mask_hi_d;
  logic                acc_q, acc_d, acc_e;
  logic                drop_q, drop_d, drop_e;
  logic [CurWidth-1:0] cur_q, cur_d, cur_e, nxt;
  logic [7:0]          held_q, held_d;

  // Hold packet tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      mask_hi_q <= '0;
      acc_q     <= 1'b0;
      drop_q    <= 1'b1;
      cur_q     <= '0;
      held_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      mask_hi_q <= mask_hi_d;
      acc_q     <= acc_d;
      drop_q    <= drop_d;
      cur_q     <= cur_d;
      held_q    <= held_d;
    end
  end

  // Classify each accepted byte and build the emit request
  always_comb begin
    pos_e  = packet_start_i ? '0 : pos_q;
    drop_e = packet_start_i ? 1'b0 : drop_q;
    acc_e  = packet_start_i ? 1'b0 : acc_q;
    cur_e  = packet_start_i ? '0 : cur_q;

    pos_d     = pos_q;
    mask_hi_d = mask_hi_q;
    acc_d     = acc_q;
    drop_d    = drop_q;
    cur_d     = cur_q;
    held_d    = held_q;
    nxt       = '0;
    req_o     = '0;

    if (accept_i) begin
      pos_d  = pos_e;
      drop_d = drop_e;
      acc_d  = acc_e;
      cur_d  = cur_e;
      if (!drop_e) begin
        pos_d = (pos_e == PosMax) ? pos_e : pos_e + 1'b1;
        if (pos_e == HdrPos) begin
          mask_hi_d = packet_byte_i;
        end else if (pos_e == MaskLoPos) begin
          if ({mask_hi_q, packet_byte_i} != channel_mask_i) begin
            // Mismatch: one status result, then wait for the next start
            drop_d                = 1'b1;
            req_o.push            = 1'b1;
            req_o.cmd.status      = 1'b1;
            req_o.cmd.first_ch    = '0;
            req_o.cmd.end_ch      = ChWidth'(1);
          end else begin
            acc_d              = 1'b1;
            nxt                = first_set(channel_mask_i, '0);
            cur_d              = nxt;
            req_o.cmd.first_ch = '0;
            req_o.cmd.end_ch   = clip_end(nxt);
            req_o.push         = (clip_end(nxt) != '0);
          end
        end else if (pos_e > MaskLoPos && acc_e && cur_e < ChDone) begin
          if (pos_e[0] == HdrPos[0]) begin
            held_d = packet_byte_i;
          end else if (cur_e < CurWidth'(ChUnused)) begin
            // Value for the current channel, then zeros up to the next set one
            nxt                 = first_set(channel_mask_i, cur_e + 1'b1);
            cur_d               = nxt;
            req_o.push          = 1'b1;
            req_o.cmd.has_value = 1'b1;
            req_o.cmd.first_ch  = cur_e[ChWidth-1:0];
            req_o.cmd.end_ch    = clip_end(nxt);
            req_o.cmd.raw       = {held_q, packet_byte_i};
          end else begin
            cur_d = ChDone;
          end
        end
      end
    end
  end

endmodule

### src/imucpu_fifo.sv
// Short request queue between the front end and the back end.
module imucpu_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  imucpu_pkg::cmd_t   push_data_i,
  input  logic               pop_i,
  output imucpu_pkg::cmd_t   pop_data_o,
  output logic               full_o,
  output logic               empty_o
);
  import imucpu_pkg::*;

  cmd_t                  store_q [FifoDepth];
  logic [FifoPtrWidth-1:0] wr_q, rd_q;
  logic [FifoPtrWidth:0]   cnt_q;

  assign full_o     = (cnt_q == (FifoPtrWidth+1)'(FifoDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = store_q[rd_q];

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Write payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_q] <= push_data_i;
    end
  end

endmodule

### src/imucpu_back.sv
// Back end: walks each request channel by channel, scales and registers results.
module imucpu_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  imucpu_pkg::cmd_t  cmd_i,
  output logic              cmd_pop_o,
  input  logic [15:0]       gain_angle_i,
  input  logic [15:0]       gain_rate_i,
  input  logic [15:0]       gain_magnet_i,
  input  logic [15:0]       gain_gyro_i,
  input  logic [15:0]       gain_accel_i,
  imucpu_res_if.source      out_if
);
  import imucpu_pkg::*;

  back_state_e         state_q, state_d;
  logic [ChWidth-1:0]  ch_q, ch_d;
  logic [ChWidth-1:0]  end_q, end_d;
  logic [15:0]         raw_q, raw_d;
  logic                hasv_q, hasv_d;
  logic                stat_q, stat_d;

  logic                out_valid_q, out_valid_d;
  logic [ChWidth-1:0]  out_ch_q;
  logic signed [15:0]  out_raw_q;
  logic signed [31:0]  out_scaled_q;
  logic                out_stat_q;
  logic                out_last_q;

  logic                slot_free;
  logic                emit;
  logic signed [15:0]  raw_cur;
  logic [15:0]         gain_cur;
  logic signed [31:0]  prod;

  assign slot_free = !out_valid_q || out_if.ready;
  assign raw_cur   = hasv_q ? $signed(raw_q) : '0;
  assign gain_cur  = gain_sel(ch_q, gain_angle_i, gain_rate_i, gain_magnet_i,
                              gain_gyro_i, gain_accel_i);
  assign prod      = 32'(raw_cur) * 32'($signed({1'b0, gain_cur}));

  // Hold walk state and output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold walk payload and drive result payload
  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    end_q  <= end_d;
    raw_q  <= raw_d;
    hasv_q <= hasv_d;
    stat_q <= stat_d;
    if (emit) begin
      out_ch_q     <= ch_q;
      out_raw_q    <= raw_cur;
      out_scaled_q <= prod;
      out_stat_q   <= stat_q;
      out_last_q   <= stat_q || (ch_q == ChLast);
    end
  end

  // Load a request, then emit one channel per free output slot
  always_comb begin
    state_d     = state_q;
    ch_d        = ch_q;
    end_d       = end_q;
    raw_d       = raw_q;
    hasv_d      = hasv_q;
    stat_d      = stat_q;
    cmd_pop_o   = 1'b0;
    emit        = 1'b0;
    out_valid_d = out_valid_q && !out_if.ready;
    case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          ch_d      = cmd_i.first_ch;
          end_d     = cmd_i.end_ch;
          raw_d     = cmd_i.raw;
          hasv_d    = cmd_i.has_value;
          stat_d    = cmd_i.status;
          state_d   = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          emit        = 1'b1;
          out_valid_d = 1'b1;
          hasv_d      = 1'b0;
          ch_d        = ch_q + 1'b1;
          if (ch_q + 1'b1 == end_q) begin
            state_d = BK_IDLE;
          end
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.channel      = out_ch_q;
  assign out_if.raw_value    = out_raw_q;
  assign out_if.scaled_value = out_scaled_q;
  assign out_if.status       = out_stat_q;
  assign out_if.last         = out_last_q;

endmodule

### src/imu_channel_packet_unpacker_top.sv
// Top level of the IMU channel packet unpacker: registers, front, queue and back.
//
// Bytes of an inertial sensor packet enter on in_if, one per request, with
// packet_start marking the first byte. After HEADER_BYTES skipped bytes, two
// bytes carry the channel mask; a mismatch against the configured mask yields
// one status result and the rest of the packet is dropped. On a match, one
// result per channel 0..14 leaves on out_if in channel order, each scaled by
// its group gain; the last result of a packet has last set.
// A byte is taken in the cycle it arrives whenever the four-entry request
// queue has room. The back end loads a request while idle, then emits one
// result per cycle while the output slot is free and takes the next request
// only after the last one; that walk sets the pace. The first result of a
// byte passes the queue, the walk registers and the output register.
// When the receiver stalls, the output register holds, the back end waits and
// the queue fills; in_if.ready falls once the queue is full.
// Reset clears all packet state, waits for a start byte and loads the default
// mask and gains. Configuration goes through cfg_we_i, cfg_idx_i and cfg_data_i;
// the user must write it only while the block is idle, the block does not check.
module imu_channel_packet_unpacker_top #(
  parameter int unsigned HEADER_BYTES = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  imucpu_byte_if.sink in_if,
  imucpu_res_if.source out_if
);
  import imucpu_pkg::*;

  logic [15:0] mask_q;
  logic [15:0] g_angle_q, g_rate_q, g_magnet_q, g_gyro_q, g_accel_q;

  front_req_t  front_req;
  cmd_t        fifo_cmd;
  logic        fifo_full, fifo_empty, fifo_pop;
  logic        in_accept;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q     <= RstChannelMask;
      g_angle_q  <= RstGainAngle;
      g_rate_q   <= RstGainRate;
      g_magnet_q <= RstGainMagnet;
      g_gyro_q   <= RstGainGyro;
      g_accel_q  <= RstGainAccel;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgChannelMask: mask_q     <= cfg_data_i;
        CfgGainAngle:   g_angle_q  <= cfg_data_i;
        CfgGainRate:    g_rate_q   <= cfg_data_i;
        CfgGainMagnet:  g_magnet_q <= cfg_data_i;
        CfgGainGyro:    g_gyro_q   <= cfg_data_i;
        CfgGainAccel:   g_accel_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Take a byte whenever the queue has room
  assign in_if.ready = !fifo_full;
  assign in_accept   = in_if.valid && !fifo_full;

  imucpu_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (in_accept),
    .packet_byte_i  (in_if.packet_byte),
    .packet_start_i (in_if.packet_start),
    .channel_mask_i (mask_q),
    .req_o          (front_req)
  );

  imucpu_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (front_req.push),
    .push_data_i (front_req.cmd),
    .pop_i       (fifo_pop),
    .pop_data_o  (fifo_cmd),
    .full_o      (fifo_full),
    .empty_o     (fifo_empty)
  );

  imucpu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (!fifo_empty),
    .cmd_i         (fifo_cmd),
    .cmd_pop_o     (fifo_pop),
    .gain_angle_i  (g_angle_q),
    .gain_rate_i   (g_rate_q),
    .gain_magnet_i (g_magnet_q),
    .gain_gyro_i   (g_gyro_q),
    .gain_accel_i  (g_accel_q),
    .out_if        (out_if)
  );

`ifndef SYNTHESIS
  // Queue never takes a request while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(front_req.push && fifo_full))
    else $error("request pushed into full queue");

  // Queue never pops while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_pop && fifo_empty))
    else $error("request popped from empty queue");

  // A mismatch result is a lone zero result closing the packet
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.status) |->
      (out_if.last && out_if.channel == '0 && out_if.raw_value == '0
       && out_if.scaled_value == '0))
    else $error("malformed mismatch result");

  // The unused last slot never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_if.valid |-> (out_if.channel != ChUnused))
    else $error("result for unused channel slot");
`endif

endmodule
